// ----- hdl/rcdram_pkg.sv -----
// Shared types and constants for the RAS/CAS DRAM array model.
`timescale 1ns / 1ps
`default_nettype none
package rcdram_pkg;

	localparam int DELAY_W = 8;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd10;

	// output phase of the read path
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PENDING = 2'd1,
		PH_DRIVE   = 2'd2
	} phase_t;

	// per-transaction flags handed from the control stage to the output stage
	typedef struct packed {
		logic load;   // take the array read data into the read latch
		logic drive;  // outputs driven after this tick
	} s1_flags_t;

endpackage
`default_nettype wire

// ----- hdl/ras_cas_dram_array_model.sv -----
// Top level of the RAS/CAS DRAM array model: stream ports, read stage and output register.
//
// Channel  Dir  Fields (low bit first)                          Handshake
// s_axis   in   tdata: ras_n, cas_n, we_n, addr, data_in, pad   tvalid/tready
// m_axis   out  tdata: data_out, pad; tuser: out_driven         tvalid/tready
// cfg      in   cfg_wdata: access_delay                         cfg_we, no wait
//
// One input transaction per clock unless the output stalls; each gives one output
// transaction. Control stage: edge detection, latches and array write or read issue;
// output stage: read data into the read latch and the output register.
// Reset restores strobe levels, latches and access_delay; the array is not cleared.
// A stalled output holds the stages behind it; s_axis_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none
module ras_cas_dram_array_model #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 8
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire logic                                                cfg_we,
	input  wire logic [rcdram_pkg::DELAY_W-1:0]                      cfg_wdata,
	input  wire logic                                                s_axis_tvalid,
	output logic                                                     s_axis_tready,
	// ras_n, cas_n, we_n, addr, data_in, zero pad
	input  wire logic [((3+ADDR_BITS+DATA_BITS+7)/8)*8-1:0]          s_axis_tdata,
	output logic                                                     m_axis_tvalid,
	input  wire logic                                                m_axis_tready,
	// data_out, zero pad
	output logic      [((DATA_BITS+7)/8)*8-1:0]                      m_axis_tdata,
	// out_driven
	output logic                                                     m_axis_tuser
);

	import rcdram_pkg::*;

	localparam int CW     = 2 * ADDR_BITS;
	localparam int OUT_W  = ((DATA_BITS + 7) / 8) * 8;

	logic                 accept;
	logic                 mem_we, mem_re;
	logic [CW-1:0]        mem_waddr, mem_raddr;
	logic [DATA_BITS-1:0] mem_wdata, mem_rdata;
	s1_flags_t            flags, flags_s1;
	logic                 valid_s1, adv_s1;
	logic [DATA_BITS-1:0] read_latch_q, latch_val;
	logic                 out_valid_q, out_drv_q;
	logic [DATA_BITS-1:0] out_data_q;

	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	rcdram_ctrl #(
		.ADDR_BITS(ADDR_BITS),
		.DATA_BITS(DATA_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.ras_n     (s_axis_tdata[0]),
		.cas_n     (s_axis_tdata[1]),
		.we_n      (s_axis_tdata[2]),
		.addr      (s_axis_tdata[3 +: ADDR_BITS]),
		.data_in   (s_axis_tdata[3+ADDR_BITS +: DATA_BITS]),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.flags     (flags)
	);

	rcdram_mem #(
		.AW(CW),
		.DW(DATA_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_s1 <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			flags_s1 <= flags;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// array read data is held in the RAM output register until this stage moves on
	assign latch_val = flags_s1.load ? mem_rdata : read_latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_latch_q <= '0;
		end else if (adv_s1 && flags_s1.load) begin
			read_latch_q <= mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_drv_q  <= flags_s1.drive;
			out_data_q <= flags_s1.drive ? latch_val : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);
	assign m_axis_tuser  = out_drv_q;

endmodule
`default_nettype wire

// ----- hdl/rcdram_mem.sv -----
// Cell array: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rcdram_mem #(
	parameter int AW = 14,
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/rcdram_ctrl.sv -----
// Strobe edge detection, address latches, read countdown and array access control.
`timescale 1ns / 1ps
`default_nettype none
module rcdram_ctrl #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rcdram_pkg::DELAY_W-1:0]    cfg_wdata,
	input  wire logic                              accept,
	input  wire logic                              ras_n,
	input  wire logic                              cas_n,
	input  wire logic                              we_n,
	input  wire logic [ADDR_BITS-1:0]              addr,
	input  wire logic [DATA_BITS-1:0]              data_in,
	output logic                                   mem_we,
	output logic      [2*ADDR_BITS-1:0]            mem_waddr,
	output logic      [DATA_BITS-1:0]              mem_wdata,
	output logic                                   mem_re,
	output logic      [2*ADDR_BITS-1:0]            mem_raddr,
	output rcdram_pkg::s1_flags_t                  flags
);

	import rcdram_pkg::*;

	logic [DELAY_W-1:0]   access_delay_q;
	logic                 prev_ras_q, prev_cas_q, prev_we_q;
	logic [ADDR_BITS-1:0] row_q, col_q;
	phase_t               phase_q, phase_d;
	logic [DELAY_W-1:0]   wait_q, wait_d, wait_dec;
	logic [ADDR_BITS-1:0] row_d, col_d;
	logic                 ras_fall, col_strobe, late_wr, load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			access_delay_q <= cfg_wdata;
		end
	end

	always_comb begin
		ras_fall   = !ras_n && prev_ras_q;
		col_strobe = !ras_n && !cas_n && prev_cas_q;
		late_wr    = !ras_n && !cas_n && !we_n && prev_we_q;
		// countdown runs every accepted tick while pending; only a read column strobe reloads it
		wait_dec   = (phase_q == PH_PENDING && wait_q != '0) ? wait_q - 1'b1 : wait_q;
		row_d      = row_q;
		col_d      = col_q;
		phase_d    = phase_q;
		wait_d     = wait_dec;
		load       = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = {row_q, col_q};
		if (ras_fall) begin
			row_d = addr;
		end else if (col_strobe) begin
			col_d     = addr;
			mem_waddr = {row_q, addr};
			if (!we_n) begin
				mem_we = 1'b1;   // early write
			end else begin
				wait_d  = access_delay_q;
				phase_d = PH_PENDING;
			end
		end else if (late_wr) begin
			mem_we = 1'b1;
		end else begin
			if (phase_q == PH_PENDING && wait_dec == '0) begin
				load    = 1'b1;
				phase_d = PH_DRIVE;
			end
			if (phase_d == PH_DRIVE && cas_n) begin
				phase_d = PH_IDLE;
			end
		end
		mem_we      = mem_we && accept;
		mem_wdata   = data_in;
		mem_re      = load && accept;
		mem_raddr   = {row_q, col_q};
		flags.load  = load;
		flags.drive = (phase_d == PH_DRIVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ras_q <= 1'b1;
			prev_cas_q <= 1'b1;
			prev_we_q  <= 1'b1;
			row_q      <= '0;
			col_q      <= '0;
			phase_q    <= PH_IDLE;
			wait_q     <= '0;
		end else if (accept) begin
			prev_ras_q <= ras_n;
			prev_cas_q <= cas_n;
			prev_we_q  <= we_n;
			row_q      <= row_d;
			col_q      <= col_d;
			phase_q    <= phase_d;
			wait_q     <= wait_d;
		end
	end

endmodule
`default_nettype wire
